FILE: sv/rsfe_pkg.sv
// shared types, constants and frame tables for the remote switch frame encoder
package rsfe_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned FRAME_LEN   = 36;
    localparam int unsigned PAY_W       = 24;
    localparam int unsigned POS_W       = 6;

    localparam logic [7:0] PULSE_ZERO = 8'd84;
    localparam logic [7:0] PULSE_ONE  = 8'd69;
    localparam logic [7:0] SYNC_BYTE  = 8'd85;
    localparam logic [7:0] END_BYTE   = 8'd43;

    localparam logic [3:0] CHECK_INIT = 4'h5;
    localparam logic [7:0] LOW_WRAP   = 8'h12;

    localparam logic [POS_W-1:0] PREAMBLE_LEN = POS_W'(10);
    localparam logic [POS_W-1:0] PULSE_END    = POS_W'(34);
    localparam logic [POS_W-1:0] SYNC_POS     = POS_W'(34);
    localparam logic [POS_W-1:0] LAST_POS     = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] BIT_BASE     = POS_W'(33);

    typedef enum logic [1:0] {
        CMD_ON    = 2'd0,
        CMD_OFF   = 2'd1,
        CMD_LEARN = 2'd2,
        CMD_NONE  = 2'd3
    } t_command;

    localparam logic [3:0] ACT_ON    = 4'd15;
    localparam logic [3:0] ACT_OFF   = 4'd0;
    localparam logic [3:0] ACT_LEARN = 4'd10;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    localparam logic [3:0] NIBBLE_TAB [16] = '{
        4'hf, 4'ha, 4'h7, 4'he,
        4'hf, 4'hd, 4'h9, 4'h1,
        4'h1, 4'h2, 4'h4, 4'h8,
        4'h3, 4'h6, 4'hc, 4'hb
    };

    function automatic logic [7:0] preamble_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'd82;
            4'd1:    b = 8'd5;
            4'd2:    b = 8'd84;
            4'd3:    b = 8'd114;
            4'd4:    b = 8'd60;
            4'd5:    b = 8'd1;
            4'd6:    b = 8'd1;
            4'd7:    b = 8'd105;
            4'd8:    b = 8'd85;
            4'd9:    b = 8'd85;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/rsfe_front.sv
// front end: classifies commands and builds the 24-bit payload
module rsfe_front (
    input  logic                      i_valid,
    input  logic [1:0]                i_command,
    input  logic [13:0]               i_house,
    input  logic [2:0]                i_unit,
    input  rsfe_pkg::t_queue_stat     i_qstat,
    output logic                      o_stall,
    output logic                      o_push,
    output logic [rsfe_pkg::PAY_W-1:0] o_payload
);
    import rsfe_pkg::*;

    logic [1:0]  unit_idx;
    logic [3:0]  action;
    logic        supported;
    logic [15:0] code;
    logic [15:0] adj;
    logic [8:0]  lo_sum;
    logic [3:0]  check;

    always_comb begin
        unique case (t_command'(i_command))
            CMD_ON:    begin action = ACT_ON;    supported = 1'b1; end
            CMD_OFF:   begin action = ACT_OFF;   supported = 1'b1; end
            CMD_LEARN: begin action = ACT_LEARN; supported = 1'b1; end
            default:   begin action = ACT_OFF;   supported = 1'b0; end
        endcase
    end

    always_comb begin
        if (i_unit == 3'd0) begin
            unit_idx = 2'd0;
        end else if (i_unit >= 3'd4) begin
            unit_idx = 2'd3;
        end else begin
            unit_idx = 2'(i_unit - 3'd1);
        end
    end

    assign code   = {i_house, unit_idx};
    assign lo_sum = {1'b0, code[7:0]} + 9'd4;

    always_comb begin
        if (code[1:0] == 2'b11) begin
            adj = {code[15:8], (lo_sum[8] ? LOW_WRAP : lo_sum[7:0])};
        end else begin
            adj = code;
        end
    end

    always_comb begin
        check = CHECK_INIT;
        for (int k = 0; k < 16; k++) begin
            if (adj[k]) begin
                check = check ^ NIBBLE_TAB[k];
            end
        end
    end

    assign o_stall   = i_qstat.full;
    assign o_push    = i_valid && !i_qstat.full && supported;
    assign o_payload = {code, check, action};

endmodule

FILE: sv/rsfe_queue.sv
// short payload queue between front and back
module rsfe_queue #(
    parameter int unsigned DEPTH = rsfe_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [rsfe_pkg::PAY_W-1:0] i_data,
    input  logic                       i_pop,
    output logic [rsfe_pkg::PAY_W-1:0] o_data,
    output rsfe_pkg::t_queue_stat      o_stat
);
    import rsfe_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [PAY_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: sv/rsfe_back.sv
// back end: serializes one payload into a 36-byte frame
module rsfe_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rsfe_pkg::PAY_W-1:0] i_payload,
    input  rsfe_pkg::t_queue_stat      i_qstat,
    output logic                       o_pop,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [7:0]                 o_frame_byte,
    output logic                       o_last
);
    import rsfe_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_valid, n_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic [7:0]       cur_byte;
    logic [POS_W-1:0] bit_sel;
    logic             advance, emit, at_end;

    assign advance = !r_valid || !i_stall;
    assign emit    = advance && !i_qstat.empty;
    assign at_end  = (r_pos == LAST_POS);
    assign o_pop   = emit && at_end;
    assign bit_sel = BIT_BASE - r_pos;

    always_comb begin
        if (r_pos < PREAMBLE_LEN) begin
            cur_byte = preamble_byte(r_pos[3:0]);
        end else if (r_pos < PULSE_END) begin
            cur_byte = i_payload[bit_sel[4:0]] ? PULSE_ONE : PULSE_ZERO;
        end else if (r_pos == SYNC_POS) begin
            cur_byte = SYNC_BYTE;
        end else begin
            cur_byte = END_BYTE;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid;
        if (advance) begin
            n_valid = emit;
        end
        if (emit) begin
            n_pos = at_end ? '0 : r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= cur_byte;
            r_last <= at_end;
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_last       = r_last;

endmodule

FILE: sv/remote_switch_frame_encoder.sv
// top level of the remote switch frame encoder
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+------------------------------
//  command   | in        | i_valid / o_stall   | i_command, i_house, i_unit
//  frame     | out       | o_valid / i_stall   | o_frame_byte, o_last
//
// each supported command produces 36 frame bytes, one per cycle while i_stall is low, from the output register
// a new command is taken whenever the queue is not full, also while an earlier frame is still being serialized
// the payload queue holds up to QUEUE_DEPTH payloads, the one being serialized included
// synchronous active-low reset empties the queue and the output register
// i_stall holds the current byte; o_stall rises only while the queue is full
module remote_switch_frame_encoder #(
    parameter int unsigned QUEUE_DEPTH = rsfe_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [13:0] i_house,
    input  logic [2:0]  i_unit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_last
);
    import rsfe_pkg::*;

    t_queue_stat      qstat;
    logic             push, pop;
    logic [PAY_W-1:0] push_data, head_data;

    rsfe_front u_front (
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_house   (i_house),
        .i_unit    (i_unit),
        .i_qstat   (qstat),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_payload (push_data)
    );

    rsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_stat  (qstat)
    );

    rsfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_payload    (head_data),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last)
    );

endmodule
